FILE: rtl/pds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

	localparam int MAX_POINTS_DEF = 64;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               final_point;
	} pt_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic               end_of_set;
		logic               overflowed;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHF_RD,
		ST_SHF,
		ST_INS,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef struct packed {
		logic ld_point;
		logic srch_start;
		logic srch_next;
		logic pos_ld_idx;
		logic pos_ld_cnt;
		logic sh_start;
		logic sh_step;
		logic ins;
		logic ovf_set;
		logic emit_rd;
		logic emit_ld;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic lt;
		logic eq;
		logic idx_last;
		logic sh_at_pos;
		logic e_last;
		logic final_pt;
		logic res_free;
	} sts_t;

	// sign bits flipped so an unsigned compare orders by signed y, then x
	function automatic logic [31:0] order_key(input logic [31:0] packed_pt);
		order_key = packed_pt ^ 32'h8000_8000;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/point_sort_dedup_unit.sv
// Per point, after its transaction: a fetch, compares in order, and for a placement among
// the held points a shift read, moves of the later points up one slot and a write; an appended
// point is written after any compares, and a duplicate or dropped point ends at the compares.
// Throughput: one point at a time, set by the sequential scan and shift of the store.
// Emission of a set: per distinct point, one store read, then one output load once res is free.
// Reset: asynchronous, clears control, count and overflow; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module point_sort_dedup_unit #(
	parameter int MAX_POINTS = pds_pkg::MAX_POINTS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         pt_valid,
	output logic              pt_stall,
	input  wire pds_pkg::pt_t pt,
	output logic              res_valid,
	input  wire logic         res_stall,
	output pds_pkg::res_t     res
);

	pds_pkg::cmd_t cmd;
	pds_pkg::sts_t sts;

	pds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pds_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt        (pt),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

FILE: rtl/pds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pt_valid,
	output logic               pt_stall,
	input  wire pds_pkg::sts_t sts,
	output pds_pkg::cmd_t      cmd
);

	pds_pkg::state_t st_q;
	pds_pkg::state_t nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pds_pkg::ST_IDLE;
		end else begin
			st_q <= nxt;
		end
	end

	always_comb begin
		pds_pkg::state_t fin_st;
		fin_st   = sts.final_pt ? pds_pkg::ST_EMIT_RD : pds_pkg::ST_IDLE;
		nxt      = st_q;
		cmd      = '0;
		pt_stall = 1'b1;
		unique case (st_q)
			pds_pkg::ST_IDLE: begin
				pt_stall = 1'b0;
				if (pt_valid) begin
					cmd.ld_point = 1'b1;
					nxt          = pds_pkg::ST_SRCH_RD;
				end
			end
			pds_pkg::ST_SRCH_RD: begin
				if (sts.cnt_zero) begin
					cmd.pos_ld_cnt = 1'b1;
					nxt            = pds_pkg::ST_INS;
				end else begin
					cmd.srch_start = 1'b1;
					nxt            = pds_pkg::ST_SRCH_CMP;
				end
			end
			pds_pkg::ST_SRCH_CMP: begin
				if (sts.lt) begin
					if (!sts.idx_last) begin
						cmd.srch_next = 1'b1;
					end else if (sts.cnt_full) begin
						cmd.ovf_set = 1'b1;
						nxt         = fin_st;
					end else begin
						cmd.pos_ld_cnt = 1'b1;
						nxt            = pds_pkg::ST_INS;
					end
				end else if (sts.eq) begin
					nxt = fin_st;
				end else if (sts.cnt_full) begin
					cmd.ovf_set = 1'b1;
					nxt         = fin_st;
				end else begin
					cmd.pos_ld_idx = 1'b1;
					nxt            = pds_pkg::ST_SHF_RD;
				end
			end
			pds_pkg::ST_SHF_RD: begin
				cmd.sh_start = 1'b1;
				nxt          = pds_pkg::ST_SHF;
			end
			pds_pkg::ST_SHF: begin
				cmd.sh_step = 1'b1;
				if (sts.sh_at_pos) begin
					nxt = pds_pkg::ST_INS;
				end
			end
			pds_pkg::ST_INS: begin
				cmd.ins = 1'b1;
				nxt     = fin_st;
			end
			pds_pkg::ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				nxt         = pds_pkg::ST_EMIT_LD;
			end
			pds_pkg::ST_EMIT_LD: begin
				if (sts.res_free) begin
					cmd.emit_ld = 1'b1;
					if (sts.e_last) begin
						cmd.clr = 1'b1;
						nxt     = pds_pkg::ST_IDLE;
					end else begin
						nxt = pds_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				nxt = pds_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/pds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_datapath #(
	parameter int MAX_POINTS = pds_pkg::MAX_POINTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pds_pkg::pt_t  pt,
	input  wire pds_pkg::cmd_t cmd,
	output pds_pkg::sts_t      sts,
	output logic               res_valid,
	input  wire logic          res_stall,
	output pds_pkg::res_t      res
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [31:0]   mem_q [MAX_POINTS];
	logic [31:0]   rd_q;
	logic [31:0]   pt_q;
	logic          final_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] sh_q;
	logic [AW-1:0] e_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	pds_pkg::res_t res_q;
	logic          res_valid_q;

	logic          re;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [CW-1:0] cnt_m1;

	assign cnt_m1 = cnt_q - CW'(1);

	always_comb begin
		re    = 1'b1;
		raddr = e_q;
		priority if (cmd.srch_start) begin
			raddr = '0;
		end else if (cmd.srch_next) begin
			raddr = AW'(idx_q + AW'(1));
		end else if (cmd.sh_start) begin
			raddr = cnt_m1[AW-1:0];
		end else if (cmd.sh_step) begin
			raddr = AW'(sh_q - AW'(1));
		end else if (cmd.emit_rd) begin
			raddr = e_q;
		end else begin
			re = 1'b0;
		end
	end

	always_comb begin
		we    = cmd.sh_step | cmd.ins;
		waddr = cmd.sh_step ? AW'(sh_q + AW'(1)) : pos_q[AW-1:0];
		wdata = cmd.sh_step ? rd_q : pt_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_point) begin
			pt_q    <= {pt.point_y, pt.point_x};
			final_q <= pt.final_point;
		end
		if (cmd.srch_start) begin
			idx_q <= '0;
		end else if (cmd.srch_next) begin
			idx_q <= AW'(idx_q + AW'(1));
		end
		if (cmd.pos_ld_cnt) begin
			pos_q <= cnt_q;
		end else if (cmd.pos_ld_idx) begin
			pos_q <= CW'(idx_q);
		end
		if (cmd.sh_start) begin
			sh_q <= cnt_m1[AW-1:0];
		end else if (cmd.sh_step) begin
			sh_q <= AW'(sh_q - AW'(1));
		end
		if (cmd.emit_ld) begin
			res_q.out_x      <= rd_q[15:0];
			res_q.out_y      <= rd_q[31:16];
			res_q.end_of_set <= sts.e_last;
			res_q.overflowed <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			e_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				e_q   <= '0;
			end else begin
				if (cmd.ins) begin
					cnt_q <= CW'(cnt_q + CW'(1));
				end
				if (cmd.ovf_set) begin
					ovf_q <= 1'b1;
				end
				if (cmd.emit_ld) begin
					e_q <= AW'(e_q + AW'(1));
				end
			end
			if (cmd.emit_ld) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.cnt_zero  = (cnt_q == '0);
		sts.cnt_full  = (cnt_q == CW'(MAX_POINTS));
		sts.lt        = pds_pkg::order_key(rd_q) < pds_pkg::order_key(pt_q);
		sts.eq        = (rd_q == pt_q);
		sts.idx_last  = (CW'(CW'(idx_q) + CW'(1)) == cnt_q);
		sts.sh_at_pos = (CW'(sh_q) == pos_q);
		sts.e_last    = (CW'(CW'(e_q) + CW'(1)) == cnt_q);
		sts.final_pt  = final_q;
		sts.res_free  = !res_valid_q || !res_stall;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: rtl/pds_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          pt_valid,
	input wire logic          pt_stall,
	input wire logic          res_valid,
	input wire logic          res_stall,
	input wire pds_pkg::res_t res
);

	// stalled result transaction holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// one point in flight: busy straight after a point transaction
	a_busy_after_pt: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_stall |=> pt_stall)
		else $error("point taken while previous still in work");

	// no new points while a set is still being emitted
	a_no_pt_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.end_of_set |-> pt_stall)
		else $error("point taken in the middle of a set");

	// overflow flag is the same on every result of a set
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !res.end_of_set) ##1 res_valid
		|-> res.overflowed == $past(res.overflowed))
		else $error("overflow flag changed within a set");

endmodule

bind point_sort_dedup_unit pds_checker u_chk (.*);

`default_nettype wire
